[hw/rtl/byte_stuffing_frame_builder_core_macros.svh]
// Assertion macros for the frame builder checker.
`ifndef BYTE_STUFFING_FRAME_BUILDER_CORE_MACROS_SVH
`define BYTE_STUFFING_FRAME_BUILDER_CORE_MACROS_SVH

// Same-cycle implication.
`define BSFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bsfb assertion failed");

// Next-cycle implication.
`define BSFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bsfb assertion failed");

`endif

[hw/rtl/bsfb_pkg.sv]
`timescale 1ns / 1ps

package bsfb_pkg;

  localparam logic [7:0] FLAG_BYTE  = 8'h6E;
  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] STUFF_LEAD = 8'h00;
  localparam logic [7:0] ADDR_RESET = 8'h30;

  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_ADDR = 2'd0,
    REG_SRC_ADDR  = 2'd1,
    REG_FCS_BYTE  = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_FLAG,
    ST_DEST,
    ST_SRC,
    ST_PAYLOAD,
    ST_ESC,
    ST_FCS
  } seq_state_e;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       done;
  } stuff_res_t;

endpackage

[hw/rtl/bsfb_payload_ram.sv]
`timescale 1ns / 1ps

module bsfb_payload_ram #(
  parameter int unsigned DEPTH  = 13,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/bsfb_stuffer.sv]
`timescale 1ns / 1ps

module bsfb_stuffer import bsfb_pkg::*; (
  input  logic [7:0] byte_i,
  input  logic       half_i,
  output stuff_res_t res_o
);

  logic is_flag;

  assign is_flag = (byte_i == FLAG_BYTE);

  always_comb begin
    if (is_flag) begin
      res_o.line_byte = half_i ? ESC_BYTE : STUFF_LEAD;
      res_o.done      = half_i;
    end else begin
      res_o.line_byte = byte_i;
      res_o.done      = 1'b1;
    end
  end

endmodule

[hw/rtl/bsfb_seq.sv]
`timescale 1ns / 1ps

module bsfb_seq import bsfb_pkg::*; #(
  parameter int unsigned DEPTH  = 13,
  parameter int unsigned ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  logic [7:0]        s_byte_i,
  input  logic [7:0]        dest_i,
  input  logic [7:0]        src_i,
  input  logic [7:0]        fcs_i,
  output logic              ram_we_o,
  output logic [ADDR_W-1:0] ram_waddr_o,
  output logic [7:0]        ram_wdata_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_raddr_o,
  input  logic [7:0]        ram_rdata_i,
  output logic [7:0]        stf_byte_o,
  output logic              stf_half_o,
  input  stuff_res_t        stf_res_i,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [7:0]        m_byte_o,
  output logic              m_last_o
);

  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);

  seq_state_e        state_q, state_d;
  logic [ADDR_W-1:0] fill_q, fill_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              half_q, half_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              advance;
  logic              load;
  logic [7:0]        ld_byte;
  logic              ld_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      fill_q      <= '0;
      idx_q       <= '0;
      half_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      idx_q       <= idx_d;
      half_q      <= half_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
  end

  assign advance     = !out_valid_q || m_ready_i;
  assign s_ready_o   = (state_q == ST_COLLECT);
  assign ram_waddr_o = fill_q;
  assign ram_wdata_o = s_byte_i;
  assign stf_half_o  = half_q;

  always_comb begin
    case (state_q)
      ST_DEST: stf_byte_o = dest_i;
      ST_SRC:  stf_byte_o = src_i;
      default: stf_byte_o = ram_rdata_i;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    half_d      = half_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_raddr_o = idx_q;
    load        = 1'b0;
    ld_byte     = stf_res_i.line_byte;
    ld_last     = 1'b0;

    case (state_q)
      ST_COLLECT: begin
        if (s_valid_i) begin
          ram_we_o = 1'b1;
          if (fill_q == LAST_IDX) begin
            fill_d  = '0;
            state_d = ST_FLAG;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      ST_FLAG: begin
        if (advance) begin
          load    = 1'b1;
          ld_byte = FLAG_BYTE;
          half_d  = 1'b0;
          state_d = ST_DEST;
        end
      end
      ST_DEST: begin
        if (advance) begin
          load   = 1'b1;
          half_d = !stf_res_i.done;
          if (stf_res_i.done) begin
            state_d = ST_SRC;
          end
        end
      end
      ST_SRC: begin
        if (advance) begin
          load   = 1'b1;
          half_d = !stf_res_i.done;
          if (stf_res_i.done) begin
            ram_re_o    = 1'b1;
            ram_raddr_o = '0;
            idx_d       = '0;
            state_d     = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        if (advance) begin
          load   = 1'b1;
          half_d = !stf_res_i.done;
          if (stf_res_i.done) begin
            if (idx_q == LAST_IDX) begin
              state_d = ST_ESC;
            end else begin
              idx_d       = idx_q + 1'b1;
              ram_re_o    = 1'b1;
              ram_raddr_o = idx_q + 1'b1;
            end
          end
        end
      end
      ST_ESC: begin
        if (advance) begin
          load    = 1'b1;
          ld_byte = ESC_BYTE;
          state_d = ST_FCS;
        end
      end
      ST_FCS: begin
        if (advance) begin
          load    = 1'b1;
          ld_byte = fcs_i;
          ld_last = 1'b1;
          state_d = ST_COLLECT;
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase

    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = load;
      if (load) begin
        out_byte_d = ld_byte;
        out_last_d = ld_last;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_byte_o  = out_byte_q;
  assign m_last_o  = out_last_q;

endmodule

[hw/rtl/byte_stuffing_frame_builder_core.sv]
`timescale 1ns / 1ps

// Byte-stuffing frame builder. Each payload transaction on the slave side is
// written to the payload memory. The transaction that completes PAYLOAD_BYTES
// bytes starts a frame: flag 0x6E, destination, source, payload, escape 0x1B
// and the FCS byte (tlast), with every 0x6E among destination, source and
// payload sent as 0x00 0x1B. The frame, PAYLOAD_BYTES + 5 to 2 * PAYLOAD_BYTES
// + 7 bytes long, leaves through an output register at one byte per cycle
// while the master side is ready. The sequencer walks the payload memory one
// entry at a time and holds s_axis_tready low from the final payload byte
// until the FCS byte is in the output register.
// Configuration writes (index 0 destination, 1 source, 2 FCS) are always
// ready and should be made while no frame is in flight.
module byte_stuffing_frame_builder_core import bsfb_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,  // [7:0] data_byte
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,  // [7:0] out_byte
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i
);

  localparam int unsigned ADDR_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  logic [7:0]        dest_q, src_q, fcs_q;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic [7:0]        stf_byte;
  logic              stf_half;
  stuff_res_t        stf_res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q <= ADDR_RESET;
      src_q  <= ADDR_RESET;
      fcs_q  <= ADDR_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEST_ADDR: dest_q <= cfg_data_i;
        REG_SRC_ADDR:  src_q  <= cfg_data_i;
        REG_FCS_BYTE:  fcs_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bsfb_payload_ram #(
    .DEPTH  (PAYLOAD_BYTES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bsfb_stuffer u_stuffer (
    .byte_i (stf_byte),
    .half_i (stf_half),
    .res_o  (stf_res)
  );

  bsfb_seq #(
    .DEPTH  (PAYLOAD_BYTES),
    .ADDR_W (ADDR_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_byte_i    (s_axis_tdata),
    .dest_i      (dest_q),
    .src_i       (src_q),
    .fcs_i       (fcs_q),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .stf_byte_o  (stf_byte),
    .stf_half_o  (stf_half),
    .stf_res_i   (stf_res),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_byte_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

[hw/rtl/bsfb_checker.sv]
`timescale 1ns / 1ps
`include "byte_stuffing_frame_builder_core_macros.svh"

module bsfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  `BSFB_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `BSFB_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast))
  `BSFB_ASSERT_NOW(a_in_ready_only_at_end, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)
  `BSFB_ASSERT_NEXT(a_quiet_after_frame, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tlast && s_axis_tready, !m_axis_tvalid)

endmodule

bind byte_stuffing_frame_builder_core bsfb_checker u_bsfb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[verif/bsfb_frame_checker.sv]
`timescale 1ns / 1ps

module bsfb_frame_checker import bsfb_pkg::*; #(
  parameter int unsigned PAYLOAD_BYTES = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [7:0]           s_tdata_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [7:0]           m_tdata_i,
  input  logic                 m_tlast_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]           cfg_data_i,
  output int                   mismatches_o,
  output int                   pending_o
);

  logic [7:0]  dest_addr;
  logic [7:0]  src_addr;
  logic [7:0]  fcs_val;
  logic [7:0]  payload_mem [PAYLOAD_BYTES];
  int unsigned fill;
  int          errs;
  stuff_res_t  line_q [$];

  function automatic void push_line(input logic [7:0] b, input logic last);
    stuff_res_t r;
    r.line_byte = b;
    r.done      = last;
    line_q.push_back(r);
  endfunction

  function automatic void push_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE) begin
      push_line(STUFF_LEAD, 1'b0);
      push_line(ESC_BYTE, 1'b0);
    end else begin
      push_line(b, 1'b0);
    end
  endfunction

  function automatic void queue_frame();
    push_line(FLAG_BYTE, 1'b0);
    push_stuffed(dest_addr);
    push_stuffed(src_addr);
    for (int i = 0; i < PAYLOAD_BYTES; i++) push_stuffed(payload_mem[i]);
    push_line(ESC_BYTE, 1'b0);
    push_line(fcs_val, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stuff_res_t want;
    if (!rst_ni) begin
      dest_addr = ADDR_RESET;
      src_addr  = ADDR_RESET;
      fcs_val   = ADDR_RESET;
      fill      = 0;
      errs      = 0;
      line_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DEST_ADDR: dest_addr = cfg_data_i;
          REG_SRC_ADDR:  src_addr  = cfg_data_i;
          REG_FCS_BYTE:  fcs_val   = cfg_data_i;
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (line_q.size() == 0) begin
          $display("%0t: unexpected transaction expected none actual out_byte %02h frame_end %b",
                   $time, m_tdata_i, m_tlast_i);
          errs++;
        end else begin
          want = line_q.pop_front();
          if (m_tdata_i !== want.line_byte) begin
            $display("%0t: out_byte expected %02h actual %02h",
                     $time, want.line_byte, m_tdata_i);
            errs++;
          end
          if (m_tlast_i !== want.done) begin
            $display("%0t: frame_end expected %b actual %b",
                     $time, want.done, m_tlast_i);
            errs++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (fill >= PAYLOAD_BYTES) fill = 0;
        payload_mem[fill] = s_tdata_i;
        fill++;
        if (fill == PAYLOAD_BYTES) begin
          queue_frame();
          fill = 0;
        end
      end
      mismatches_o <= errs;
      pending_o    <= line_q.size();
    end
  end

endmodule

[verif/tb_byte_stuffing_frame_builder_core.sv]
`timescale 1ns / 1ps

module tb_byte_stuffing_frame_builder_core;
  import bsfb_pkg::*;

  localparam int unsigned FRAME_PAYLOAD = 13;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_CYCLES  = 40;
  localparam int          LIMIT_CYCLES  = 200000;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
  localparam logic [FRAME_PAYLOAD*8-1:0] MIXED_BYTES =
    {8'hFE, 8'hAA, 8'h55, 8'h00, 8'h6E, 8'h6E, 8'h7F, 8'h80, 8'h01, 8'h1B, 8'h6E,
     8'hFF, 8'h00};

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'h00;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_DEST_ADDR;
  logic [7:0]           cfg_data_i = 8'h00;

  int mismatches;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int hold_left = 0;
  int cycles = 0;

  byte_stuffing_frame_builder_core #(
    .PAYLOAD_BYTES(FRAME_PAYLOAD)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  bsfb_frame_checker #(
    .PAYLOAD_BYTES(FRAME_PAYLOAD)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // line side: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else begin
      m_axis_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0, 1:    return FLAG_BYTE;
      2:       return ESC_BYTE;
      3:       return $urandom_range(1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_cfg();
    return $urandom_range(2) == 0 ? FLAG_BYTE : 8'($urandom_range(255));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // all frames out, then a short pause for the last stored byte
  task automatic settle();
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int n_items;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all-flag frame: addresses and payload stuffed, flag in FCS sent raw
    write_reg(REG_DEST_ADDR, FLAG_BYTE);
    write_reg(REG_SRC_ADDR, FLAG_BYTE);
    write_reg(REG_FCS_BYTE, FLAG_BYTE);
    write_reg(REG_NONE, 8'h00);
    for (int i = 0; i < FRAME_PAYLOAD; i++) send_byte(FLAG_BYTE);
    end_burst();

    settle();
    write_reg(REG_DEST_ADDR, 8'h00);
    write_reg(REG_SRC_ADDR, 8'hFF);
    write_reg(REG_FCS_BYTE, 8'hFF);
    write_reg(REG_NONE, 8'hFF);
    for (int i = 0; i < FRAME_PAYLOAD; i++) send_byte(MIXED_BYTES[i*8 +: 8]);
    end_burst();

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      if (ph == 0) begin
        write_reg(REG_DEST_ADDR, 8'hFF);
        write_reg(REG_SRC_ADDR, 8'h00);
        write_reg(REG_FCS_BYTE, 8'h00);
      end else begin
        write_reg(REG_DEST_ADDR, pick_cfg());
        write_reg(REG_SRC_ADDR, pick_cfg());
        write_reg(REG_FCS_BYTE, pick_cfg());
        if ($urandom_range(1) == 1) write_reg(REG_NONE, pick_cfg());
      end
      n_items = 30;
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        3: begin send_idle_pct = 37; recv_stall_pct = 37; end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_req <= 1'b1;
          n_items = 25;
        end
      endcase
      for (int i = 0; i < n_items; i++) send_byte(pick_byte());
      end_burst();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
